@@ design/cell_voltage_fault_qualifier_macros.svh @@
// assertion helpers for the cell voltage fault qualifier
`ifndef CELL_VOLTAGE_FAULT_QUALIFIER_MACROS_SVH
`define CELL_VOLTAGE_FAULT_QUALIFIER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define CVFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define CVFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cvfq_pkg.sv @@
package cvfq_pkg;

    localparam int unsigned MV_TO_UV  = 1000;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 136;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;
    localparam int unsigned IDX_W     = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_MAX_MV  = 3'd0,
        CFG_CELL_MIN_MV  = 3'd1,
        CFG_FAULT_THRESH = 3'd2,
        CFG_ADC_LSB_UV   = 3'd3,
        CFG_ADC_OFFSET   = 3'd4
    } t_cfg_idx;

    localparam logic [25:0]        RST_MAX_UV = 26'd4200000;
    localparam logic [25:0]        RST_MIN_UV = 26'd2500000;
    localparam logic [7:0]         RST_THRESH = 8'd3;
    localparam logic [9:0]         RST_LSB_UV = 10'd150;
    localparam logic signed [23:0] RST_OFF_UV = 24'sd1500000;
    localparam logic [7:0]         CNT_SAT    = 8'hFF;

    typedef struct packed {
        logic signed [26:0] pv;
        logic signed [26:0] sv;
        logic [7:0]         cnt;
    } t_cell_word;

    typedef struct packed {
        logic signed [15:0] red;
        logic signed [15:0] prim;
        logic [6:0]         idx;
    } t_in_fields;

    typedef struct packed {
        logic [4:0]         pad;
        logic [7:0]         bad_reads;
        logic               mm_valid;
        logic [25:0]        max_uv;
        logic [25:0]        min_uv;
        logic signed [33:0] total_uv;
        logic               fault;
        logic [7:0]         vcount;
        logic signed [26:0] cell_uv;
    } t_out_data;

endpackage

@@ design/cell_voltage_fault_qualifier.sv @@
// cell voltage fault qualifier
// slave stream: one beat per cell reading; tdata holds cell index, primary and
// redundant ADC codes, tuser the PEC-error flag, tlast the last cell of a scan.
// master stream: one result beat per input beat, in order; tdata holds the
// stored primary voltage, violation count, fault flag and scan statistics
// (nonzero only on the tlast beat), tuser the stale-reading flag.
// config port: index/data write channel, always ready; write only while idle.
// throughput: one beat per cycle unless the output stalls. the ADC scaling
// multiply sits before the input register, the per-cell store is a one-port-write
// memory read at accept with a bypass from the item leaving that same cycle.
// an accepted beat passes the input register, then the output register.
// reset: limits and ADC constants return to defaults, scan statistics clear,
// per-cell valid bits clear so every cell reads as zero volts and count zero;
// no clearing pass, items are taken right after reset.
// stall: with tready low the output register and the input stage both hold;
// o_s_tready drops only once both are full, no beat is dropped or repeated.
`include "cell_voltage_fault_qualifier_macros.svh"

module cell_voltage_fault_qualifier #(
    parameter int CELL_COUNT = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // cell_index[6:0], primary_code[22:7], redundant_code[38:23], zero[39]
    input  logic [cvfq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // pec_error[0]
    input  logic [0:0]                       i_s_tuser,
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // cell_voltage_uv[26:0], violation_count[34:27], fault_raised[35],
    // pack_total_uv[69:36], pack_min_uv[95:70], pack_max_uv[121:96],
    // min_max_valid[122], scan_bad_reads[130:123], zero[135:131]
    output logic [cvfq_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // stale_reading[0]
    output logic [0:0]                       o_m_tuser,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cvfq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cvfq_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import cvfq_pkg::*;

    localparam int DEPTH = (CELL_COUNT < (1 << IDX_W)) ? CELL_COUNT : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [25:0]        r_max_uv;
    logic [25:0]        r_min_uv;
    logic [7:0]         r_thresh;
    logic [9:0]         r_lsb;
    logic signed [23:0] r_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_uv <= RST_MAX_UV;
            r_min_uv <= RST_MIN_UV;
            r_thresh <= RST_THRESH;
            r_lsb    <= RST_LSB_UV;
            r_off    <= RST_OFF_UV;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CELL_MAX_MV:  r_max_uv <= 26'(32'(i_cfg_data[15:0]) * MV_TO_UV);
                CFG_CELL_MIN_MV:  r_min_uv <= 26'(32'(i_cfg_data[15:0]) * MV_TO_UV);
                CFG_FAULT_THRESH: r_thresh <= i_cfg_data[7:0];
                CFG_ADC_LSB_UV:   r_lsb    <= i_cfg_data[9:0];
                CFG_ADC_OFFSET:   r_off    <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // input side: scaling and store read
    t_in_fields         w_in;
    logic               w_accept;
    logic               w_fire;
    logic               w_in_inside;
    logic [AW-1:0]      w_raddr;
    logic signed [26:0] w_lsb_s;
    logic signed [26:0] n_fp;
    logic signed [26:0] n_fs;

    assign w_in        = t_in_fields'(i_s_tdata[38:0]);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_inside = 32'(w_in.idx) < DEPTH;
    assign w_raddr     = w_in_inside ? w_in.idx[AW-1:0] : '0;
    assign w_lsb_s     = signed'(27'({1'b0, r_lsb}));
    assign n_fp        = 27'(signed'(w_in.prim)) * w_lsb_s + 27'(r_off);
    assign n_fs        = 27'(signed'(w_in.red)) * w_lsb_s + 27'(r_off);

    logic               r_s1_vld;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s1_inside;
    logic signed [26:0] r_s1_fp;
    logic signed [26:0] r_s1_fs;
    logic               r_s1_pec;
    logic               r_s1_last;
    logic               r_byp;
    t_cell_word         r_fwd;
    t_cell_word         r_rd;
    logic               r_rd_vld;
    t_cell_word         r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;

    logic               r_out_vld;
    t_out_data          r_out;
    logic               r_out_stale;
    logic               r_out_last;

    assign w_fire     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || w_fire;

    // cell update
    t_cell_word         w_old;
    t_cell_word         n_cell;
    logic               w_both_oor;
    logic               n_fault;
    logic [AW-1:0]      w_waddr;

    function automatic logic out_of_range(logic signed [26:0] uv, logic [25:0] hi,
                                          logic [25:0] lo);
        return (uv > signed'({1'b0, hi})) || (uv < signed'({1'b0, lo}));
    endfunction

    assign w_waddr = r_s1_idx[AW-1:0];

    always_comb begin
        if (!r_s1_inside) begin
            w_old = '0;
        end else if (r_byp) begin
            w_old = r_fwd;
        end else if (r_rd_vld) begin
            w_old = r_rd;
        end else begin
            w_old = '0;
        end
        n_cell.pv  = r_s1_pec ? w_old.pv : r_s1_fp;
        n_cell.sv  = r_s1_pec ? w_old.sv : r_s1_fs;
        w_both_oor = out_of_range(n_cell.pv, r_max_uv, r_min_uv)
                  && out_of_range(n_cell.sv, r_max_uv, r_min_uv);
        n_fault    = 1'b0;
        if (!w_both_oor) begin
            n_cell.cnt = '0;
        end else if (w_old.cnt != CNT_SAT) begin
            n_cell.cnt = w_old.cnt + 8'd1;
            n_fault    = (n_cell.cnt == r_thresh);
        end else begin
            n_cell.cnt = w_old.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_s1_inside) begin
            r_mem[w_waddr] <= n_cell;
        end
        if (w_accept) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_s1_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            if (w_fire && r_s1_inside) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (w_accept) begin
                r_s1_vld <= 1'b1;
                r_byp    <= w_fire && r_s1_inside && (r_s1_idx == w_in.idx);
            end else if (w_fire) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_fwd <= n_cell;
        end
        if (w_accept) begin
            r_s1_idx    <= w_in.idx;
            r_s1_inside <= w_in_inside;
            r_s1_fp     <= n_fp;
            r_s1_fs     <= n_fs;
            r_s1_pec    <= i_s_tuser[0];
            r_s1_last   <= i_s_tlast;
            r_rd_vld    <= r_vld[w_raddr];
        end
    end

    // scan statistics
    logic signed [33:0] r_tot;
    logic [25:0]        r_min;
    logic [25:0]        r_max;
    logic               r_seen;
    logic [7:0]         r_bad;
    logic signed [33:0] n_tot;
    logic [25:0]        n_min;
    logic [25:0]        n_max;
    logic               n_seen;
    logic [7:0]         n_bad;
    logic               w_contrib;
    logic [25:0]        w_u;

    assign w_contrib = !r_s1_pec && !r_s1_fp[26];
    assign w_u       = r_s1_fp[25:0];

    always_comb begin
        n_tot  = r_s1_pec ? r_tot : r_tot + 34'(r_s1_fp);
        n_min  = (w_contrib && (w_u < r_min)) ? w_u : r_min;
        n_max  = (w_contrib && (w_u > r_max)) ? w_u : r_max;
        n_seen = r_seen || w_contrib;
        n_bad  = (r_s1_pec && (r_bad != CNT_SAT)) ? r_bad + 8'd1 : r_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot  <= '0;
            r_min  <= '1;
            r_max  <= '0;
            r_seen <= 1'b0;
            r_bad  <= '0;
        end else if (w_fire) begin
            if (r_s1_last) begin
                r_tot  <= '0;
                r_min  <= '1;
                r_max  <= '0;
                r_seen <= 1'b0;
                r_bad  <= '0;
            end else begin
                r_tot  <= n_tot;
                r_min  <= n_min;
                r_max  <= n_max;
                r_seen <= n_seen;
                r_bad  <= n_bad;
            end
        end
    end

    // result register
    t_out_data n_out;

    always_comb begin
        n_out           = '0;
        n_out.cell_uv   = n_cell.pv;
        n_out.vcount    = n_cell.cnt;
        n_out.fault     = n_fault;
        if (r_s1_last) begin
            n_out.total_uv  = n_tot;
            n_out.bad_reads = n_bad;
            if (n_seen) begin
                n_out.min_uv   = n_min;
                n_out.max_uv   = n_max;
                n_out.mm_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out       <= n_out;
            r_out_stale <= r_s1_pec;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out;
    assign o_m_tuser[0] = r_out_stale;
    assign o_m_tlast    = r_out_last;

    `CVFQ_ASSERT_NOW(a_fault_at_thresh, r_out_vld && r_out.fault,
        (r_out.vcount == r_thresh) && (r_out.vcount != 8'd0),
        "fault raised with count off threshold")
    `CVFQ_ASSERT_NOW(a_stats_only_at_end, r_out_vld && !r_out_last,
        (r_out.total_uv == '0) && (r_out.bad_reads == '0) && !r_out.mm_valid,
        "scan statistics on a non-final beat")
    `CVFQ_ASSERT_NOW(a_minmax_zero, r_out_vld && !r_out.mm_valid,
        (r_out.min_uv == '0) && (r_out.max_uv == '0),
        "min or max set without a contributing cell")
    `CVFQ_ASSERT_NEXT(a_stats_restart, w_fire && r_s1_last,
        (r_tot == '0) && (r_bad == '0) && !r_seen && (r_max == '0),
        "scan statistics not restarted after final cell")

endmodule

@@ tb/sv/tb_cell_voltage_fault_qualifier.sv @@
module tb_cell_voltage_fault_qualifier;
    import cvfq_pkg::*;

    typedef struct packed {
        logic [26:0] cell_uv;
        logic [7:0]  vcount;
        logic        fault;
        logic        stale;
        logic        done;
        logic [33:0] total;
        logic [25:0] mn;
        logic [25:0] mx;
        logic        mmv;
        logic [7:0]  bad;
    } t_cell_result;

    typedef struct {
        logic [6:0]   idx;
        logic [15:0]  prim;
        logic [15:0]  red;
        logic         pec;
        logic         eos;
        bit           typed;
        t_cell_result res;
    } t_dir_row;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall;
    typedef enum int {CODE_ANY, CODE_NEAR_LO, CODE_NEAR_HI, CODE_BETWEEN} t_code_kind;

    localparam int     DIR_N     = 20;
    localparam int     NCELLS    = 128;
    localparam longint UV_PER_MV = MV_TO_UV;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic [0:0]           i_s_tuser = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]           o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    cell_voltage_fault_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the limit and adc registers
    longint lim_max_mv, lim_min_mv, fault_thresh, adc_lsb, adc_off;
    // shadow of the per-cell store and scan statistics
    longint       cell_prim_uv [NCELLS];
    longint       cell_red_uv [NCELLS];
    int unsigned  cell_vcnt [NCELLS];
    logic [33:0]  scan_total;
    logic [25:0]  scan_min, scan_max;
    bit           scan_seen;
    int unsigned  scan_bad;

    t_cell_result results_due [$];
    int           mismatches = 0;
    t_stall       stall_mode = STALL_NONE;
    bit           gaps_on = 1'b0;
    int           burst_left = 0;
    int           cyc = 0;
    int           lo_code, hi_code;

    t_dir_row dir_tab [DIR_N] = '{
        // pec errors right after reset: zero volts reads below the lower limit
        '{7'd5, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1,
          '{27'd0, 8'd1, 1'b0, 1'b1, 1'b1, 34'd0, 26'd0, 26'd0, 1'b0, 8'd1}},
        '{7'd5, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1,
          '{27'd0, 8'd2, 1'b0, 1'b1, 1'b0, 34'd0, 26'd0, 26'd0, 1'b0, 8'd0}},
        '{7'd5, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1,
          '{27'd0, 8'd3, 1'b1, 1'b1, 1'b0, 34'd0, 26'd0, 26'd0, 1'b0, 8'd0}},
        '{7'd5, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1,
          '{27'd0, 8'd4, 1'b0, 1'b1, 1'b1, 34'd0, 26'd0, 26'd0, 1'b0, 8'd3}},
        '{7'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1,
          '{27'd1500000, 8'd1, 1'b0, 1'b0, 1'b0, 34'd0, 26'd0, 26'd0, 1'b0, 8'd0}},
        '{7'd127, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b1,
          '{27'd6415050, 8'd1, 1'b0, 1'b0, 1'b0, 34'd0, 26'd0, 26'd0, 1'b0, 8'd0}},
        '{7'd126, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b0, '0},
        '{7'd10, 16'd12000, 16'd12000, 1'b0, 1'b0, 1'b0, '0},
        '{7'd11, 16'd0, 16'd12000, 1'b0, 1'b0, 1'b0, '0},
        '{7'd12, 16'd12000, 16'd0, 1'b0, 1'b0, 1'b0, '0},
        '{7'd127, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, '0},
        '{7'd127, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0},
        '{7'd127, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0},
        '{7'd127, 16'd12000, 16'h7FFF, 1'b0, 1'b0, 1'b0, '0},
        '{7'd0, 16'd18000, 16'd18001, 1'b0, 1'b0, 1'b0, '0},
        '{7'd1, 16'd18001, 16'd18001, 1'b0, 1'b0, 1'b0, '0},
        '{7'd2, 16'd6666, 16'd6666, 1'b0, 1'b0, 1'b0, '0},
        '{7'd3, 16'd6667, 16'd6666, 1'b0, 1'b0, 1'b0, '0},
        '{7'd5, 16'd12000, 16'd12000, 1'b0, 1'b1, 1'b0, '0},
        // scan of one negative fresh cell: no min or max
        '{7'd20, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b0, '0}
    };

    function automatic bit beyond_limits(longint uv);
        return uv > lim_max_mv * UV_PER_MV || uv < lim_min_mv * UV_PER_MV;
    endfunction

    function automatic t_cell_result qualify_cell(logic [6:0] idx, logic signed [15:0] pc,
                                                  logic signed [15:0] rc, logic pec,
                                                  logic eos);
        longint       pv, sv;
        int unsigned  cnt;
        bit           fault;
        t_cell_result r;
        pv = cell_prim_uv[idx];
        sv = cell_red_uv[idx];
        cnt = cell_vcnt[idx];
        fault = 1'b0;
        r = '0;
        if (pec) begin
            if (scan_bad < 255) scan_bad++;
        end else begin
            pv = longint'(pc) * adc_lsb + adc_off;
            sv = longint'(rc) * adc_lsb + adc_off;
            scan_total = scan_total + pv[33:0];
            if (pv >= 0) begin
                if (pv[25:0] < scan_min) scan_min = pv[25:0];
                if (pv[25:0] > scan_max) scan_max = pv[25:0];
                scan_seen = 1'b1;
            end
        end
        if (beyond_limits(pv) && beyond_limits(sv)) begin
            if (cnt < 255) begin
                cnt++;
                fault = (cnt == fault_thresh);
            end
        end else begin
            cnt = 0;
        end
        cell_prim_uv[idx] = pv;
        cell_red_uv[idx] = sv;
        cell_vcnt[idx] = cnt;
        r.cell_uv = pv[26:0];
        r.vcount = cnt[7:0];
        r.fault = fault;
        r.stale = pec;
        r.done = eos;
        if (eos) begin
            r.total = scan_total;
            if (scan_seen) begin
                r.mn = scan_min;
                r.mx = scan_max;
                r.mmv = 1'b1;
            end
            r.bad = scan_bad[7:0];
            scan_total = '0;
            scan_min = '1;
            scan_max = '0;
            scan_seen = 1'b0;
            scan_bad = 0;
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_code(t_code_kind kind);
        int c;
        case (kind)
            CODE_ANY:     c = int'($urandom_range(0, 65535)) - 32768;
            CODE_NEAR_LO: c = lo_code + int'($urandom_range(0, 8)) - 4;
            CODE_NEAR_HI: c = hi_code + int'($urandom_range(0, 8)) - 4;
            default:      c = (hi_code > lo_code) ?
                              lo_code + int'($urandom_range(0, hi_code - lo_code)) : lo_code;
        endcase
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[15:0];
    endfunction

    task automatic check_field(string nm, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, nm, want, got);
            mismatches++;
        end
    endtask

    task automatic send_cell(logic [6:0] idx, logic [15:0] pc, logic [15:0] rc, logic pec,
                             logic eos, bit typed, t_cell_result typed_res);
        int           gap;
        t_cell_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, rc, pc, idx};
        i_s_tuser <= pec;
        i_s_tlast <= eos;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = qualify_cell(idx, pc, rc, pec, eos);
        results_due.push_back(typed ? typed_res : r);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DAT_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CELL_MAX_MV:  lim_max_mv = longint'(value[15:0]);
            CFG_CELL_MIN_MV:  lim_min_mv = longint'(value[15:0]);
            CFG_FAULT_THRESH: fault_thresh = longint'(value[7:0]);
            CFG_ADC_LSB_UV:   adc_lsb = longint'(value[9:0]);
            default:          adc_off = longint'($signed(value[23:0]));
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int lsb, int off, int min_mv, int max_mv, int thr, int n,
                             int pool, int pec_pct, bit long_scan, t_stall stall, bit gaps);
        int          k, run_left, cell_no, base;
        longint      t;
        logic [6:0]  idx;
        logic        eos, pec;
        t_code_kind  kind;
        logic [15:0] pc, rc;
        cfg_write(CFG_CELL_MAX_MV, max_mv);
        cfg_write(CFG_CELL_MIN_MV, min_mv);
        cfg_write(CFG_FAULT_THRESH, thr);
        cfg_write(CFG_ADC_LSB_UV, lsb);
        cfg_write(CFG_ADC_OFFSET, off);
        t = (lim_min_mv * UV_PER_MV - adc_off) / adc_lsb;
        lo_code = (t > 40000) ? 40000 : (t < -40000) ? -40000 : int'(t);
        t = (lim_max_mv * UV_PER_MV - adc_off) / adc_lsb;
        hi_code = (t > 40000) ? 40000 : (t < -40000) ? -40000 : int'(t);
        stall_mode = stall;
        gaps_on = gaps;
        run_left = 0;
        cell_no = 0;
        base = $urandom_range(0, NCELLS - pool);
        for (k = 0; k < n; k++) begin
            if (long_scan) begin
                idx = 7'($urandom_range(0, NCELLS - 1));
                eos = (k == n - 1);
            end else if (pool < NCELLS) begin
                idx = 7'(base + int'($urandom_range(0, pool - 1)));
                eos = ($urandom_range(0, 7) == 0);
            end else if ($urandom_range(0, 9) == 0) begin
                // stray cell outside the scan order
                idx = 7'($urandom_range(0, NCELLS - 1));
                eos = 1'($urandom_range(0, 1));
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0:       cell_no = 0;
                        1:       cell_no = 32;
                        2:       cell_no = 100;
                        default: cell_no = 120;
                    endcase
                end
                idx = cell_no[6:0];
                cell_no++;
                run_left--;
                eos = (run_left == 0);
            end
            pec = ($urandom_range(0, 99) < pec_pct);
            kind = t_code_kind'($urandom_range(0, 3));
            pc = pick_code(kind);
            rc = ($urandom_range(0, 3) == 0) ? pick_code(t_code_kind'($urandom_range(0, 3)))
                                             : pick_code(kind);
            send_cell(idx, pc, rc, pec, eos, 1'b0, '0);
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case (stall_mode)
            STALL_NONE:     i_m_tready <= 1'b1;
            STALL_LIGHT:    i_m_tready <= ($urandom_range(0, 99) >= 30);
            STALL_PERIODIC: i_m_tready <= ((cyc % 7) >= 3);
            default:        i_m_tready <= ($urandom_range(0, 99) >= 70);
        endcase
    end

    always @(posedge i_clk) begin : result_monitor
        t_cell_result want;
        t_out_data    got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_out_data'(o_m_tdata);
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("cell_voltage_uv", 64'(want.cell_uv),
                            64'($unsigned(got.cell_uv)));
                check_field("violation_count", 64'(want.vcount), 64'(got.vcount));
                check_field("fault_raised", 64'(want.fault), 64'(got.fault));
                check_field("stale_reading", 64'(want.stale), 64'(o_m_tuser[0]));
                check_field("scan_done", 64'(want.done), 64'(o_m_tlast));
                check_field("pack_total_uv", 64'(want.total),
                            64'($unsigned(got.total_uv)));
                check_field("pack_min_uv", 64'(want.mn), 64'(got.min_uv));
                check_field("pack_max_uv", 64'(want.mx), 64'(got.max_uv));
                check_field("min_max_valid", 64'(want.mmv), 64'(got.mm_valid));
                check_field("scan_bad_reads", 64'(want.bad), 64'(got.bad_reads));
            end
        end
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int p;
        int lsb, off, cmin, cmax, mn_mv, mx_mv;
        lim_max_mv = 4200;
        lim_min_mv = 2500;
        fault_thresh = 3;
        adc_lsb = 150;
        adc_off = 1500000;
        foreach (cell_prim_uv[i]) begin
            cell_prim_uv[i] = 0;
            cell_red_uv[i] = 0;
            cell_vcnt[i] = 0;
        end
        scan_total = '0;
        scan_min = '1;
        scan_max = '0;
        scan_seen = 1'b0;
        scan_bad = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall_mode = STALL_LIGHT;
        gaps_on = 1'b1;
        for (p = 0; p < DIR_N; p++) begin
            send_cell(dir_tab[p].idx, dir_tab[p].prim, dir_tab[p].red, dir_tab[p].pec,
                      dir_tab[p].eos, dir_tab[p].typed, dir_tab[p].res);
        end
        settle();

        // widest limits, steepest scale, lowest offset
        run_phase(1000, -5000000, 0, 65535, 255, 200, NCELLS, 10, 1'b0, STALL_LIGHT, 1'b1);
        // everything out of range on one cell: counter runs into saturation
        run_phase(1, 5000000, 65535, 0, 255, 300, 1, 5, 1'b0, STALL_PERIODIC, 1'b1);
        // one long scan: pack total overflows and bad reads saturate
        run_phase(1000, 5000000, 30000, 37000, 1, 640, NCELLS, 45, 1'b1, STALL_NONE, 1'b0);

        for (p = 0; p < 4; p++) begin
            lsb = $urandom_range(1, 1000);
            off = int'($urandom_range(0, 10000000)) - 5000000;
            cmin = int'($urandom_range(0, 30000)) - 20000;
            cmax = cmin + int'($urandom_range(0, 15000));
            mn_mv = (cmin * lsb + off) / 1000;
            mx_mv = (cmax * lsb + off) / 1000;
            mn_mv = (mn_mv < 0) ? 0 : (mn_mv > 65535) ? 65535 : mn_mv;
            mx_mv = (mx_mv < 0) ? 0 : (mx_mv > 65535) ? 65535 : mx_mv;
            run_phase(lsb, off, mn_mv, mx_mv, $urandom_range(1, 6), 180,
                      ($urandom_range(0, 1) != 0) ? NCELLS : $urandom_range(1, 6), 15, 1'b0,
                      t_stall'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ cell_voltage_fault_qualifier.f @@
+incdir+design
design/cvfq_pkg.sv
design/cell_voltage_fault_qualifier.sv
tb/sv/tb_cell_voltage_fault_qualifier.sv
